[rtl/core/prrs_pkg.sv]
package prrs_pkg;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_SCHED  = 2'd1,
    KIND_EXIT   = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_IDLE      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } res_status_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2
  } slot_st_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP,
    CMD_CREATE,
    CMD_FULL,
    CMD_SWITCH,
    CMD_KEEP,
    CMD_IDLE_RES,
    CMD_READ_OUT,
    CMD_EXIT,
    CMD_LK_STEP,
    CMD_LK_HIT,
    CMD_LK_MISS
  } cmd_t;

  typedef struct packed {
    logic hit_free;
    logic hit_ready;
    logic create_last;
    logic sched_last;
    logic cur_live;
    logic lk_hit;
    logic lk_last;
  } dp_status_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] context_value;
    logic [31:0] lookup_id;
  } in_t;

  typedef struct packed {
    res_status_t status;
    logic [63:0] context_out;
    logic [31:0] task_id;
    logic [3:0]  slot;
    logic        switched;
  } out_t;

endpackage

[rtl/core/process_table_round_robin_scheduler.sv]
// channel   ports                           beat taken when
// request   start, busy, in_data            start high and busy low at clk edge
// result    out_valid, out_data             out_valid high, one cycle, no stall
//
// one request in flight; a slot table scan visits one slot per cycle
// exit has no scan; create scans from slot 0, schedule from the one after cur,
// lookup from slot 0 (id ram read is registered, one slot per cycle)
// the result strobe can overlap the next request's accept cycle
// synchronous reset frees all slots at once; id and context rams need no clear
module process_table_round_robin_scheduler #(
  parameter int NUM_SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  prrs_pkg::in_t  in_data,
  output logic           out_valid,
  output prrs_pkg::out_t out_data
);

  prrs_pkg::cmd_t       cmd;
  prrs_pkg::dp_status_t stat;

  prrs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_data.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  prrs_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/core/prrs_ram.sv]
module prrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/prrs_ctrl.sv]
module prrs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  prrs_pkg::kind_t        kind,
  input  prrs_pkg::dp_status_t   stat,
  output prrs_pkg::cmd_t         cmd,
  output logic                   busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_SCHED,
    S_READ,
    S_EXIT,
    S_LK_ISSUE,
    S_LK_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = prrs_pkg::CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd = prrs_pkg::CMD_LOAD;
          case (kind)
            prrs_pkg::KIND_CREATE: state_nxt = S_CREATE;
            prrs_pkg::KIND_SCHED:  state_nxt = S_SCHED;
            prrs_pkg::KIND_EXIT:   state_nxt = S_EXIT;
            default:               state_nxt = S_LK_ISSUE;
          endcase
        end
      end
      S_CREATE: begin
        if (stat.hit_free) begin
          cmd       = prrs_pkg::CMD_CREATE;
          state_nxt = S_IDLE;
        end else if (stat.create_last) begin
          cmd       = prrs_pkg::CMD_FULL;
          state_nxt = S_IDLE;
        end else begin
          cmd = prrs_pkg::CMD_STEP;
        end
      end
      S_SCHED: begin
        if (stat.hit_ready) begin
          cmd       = prrs_pkg::CMD_SWITCH;
          state_nxt = S_READ;
        end else if (stat.sched_last) begin
          if (stat.cur_live) begin
            cmd       = prrs_pkg::CMD_KEEP;
            state_nxt = S_READ;
          end else begin
            cmd       = prrs_pkg::CMD_IDLE_RES;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd = prrs_pkg::CMD_STEP;
        end
      end
      S_READ: begin
        cmd       = prrs_pkg::CMD_READ_OUT;
        state_nxt = S_IDLE;
      end
      S_EXIT: begin
        cmd       = prrs_pkg::CMD_EXIT;
        state_nxt = S_IDLE;
      end
      S_LK_ISSUE: begin
        cmd       = prrs_pkg::CMD_LK_STEP;
        state_nxt = S_LK_SCAN;
      end
      S_LK_SCAN: begin
        if (stat.lk_hit) begin
          cmd       = prrs_pkg::CMD_LK_HIT;
          state_nxt = S_IDLE;
        end else if (stat.lk_last) begin
          cmd       = prrs_pkg::CMD_LK_MISS;
          state_nxt = S_IDLE;
        end else begin
          cmd = prrs_pkg::CMD_LK_STEP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

[rtl/core/prrs_dp.sv]
module prrs_dp #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  prrs_pkg::cmd_t       cmd,
  input  prrs_pkg::in_t        in_data,
  output prrs_pkg::dp_status_t stat,
  output logic                 out_valid,
  output prrs_pkg::out_t       out_data
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    return (v == LAST) ? '0 : v + IW'(1);
  endfunction

  function automatic logic [3:0] to_slot(input logic [IW-1:0] v);
    logic [IW+3:0] e;
    e = {4'b0, v};
    return e[3:0];
  endfunction

  prrs_pkg::slot_st_t st_r [NUM_SLOTS];
  logic [IW-1:0]      cur_r;
  logic [IW-1:0]      ptr_r;
  logic [IW-1:0]      lk_idx_r;
  logic [31:0]        next_id_r;
  logic               sw_r;
  logic               out_valid_r, out_valid_nxt;
  prrs_pkg::in_t      req_r;
  prrs_pkg::out_t     out_r, out_nxt;

  logic               id_we, ctx_we;
  logic [IW-1:0]      waddr, raddr;
  logic [63:0]        ctx_wdata;
  logic [31:0]        id_rdata;
  logic [63:0]        ctx_rdata;

  // context of the running task is saved as the schedule beat is taken
  assign id_we     = (cmd == prrs_pkg::CMD_CREATE);
  assign ctx_we    = id_we
                   || (cmd == prrs_pkg::CMD_LOAD && in_data.kind == prrs_pkg::KIND_SCHED
                       && st_r[cur_r] == prrs_pkg::ST_RUNNING);
  assign waddr     = id_we ? ptr_r : cur_r;
  assign ctx_wdata = id_we ? req_r.context_value : in_data.context_value;
  assign raddr     = (cmd == prrs_pkg::CMD_KEEP) ? cur_r : ptr_r;

  prrs_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (waddr),
    .wdata (next_id_r),
    .raddr (raddr),
    .rdata (id_rdata)
  );

  prrs_ram #(.WIDTH(64), .DEPTH(NUM_SLOTS)) u_ctx_ram (
    .clk   (clk),
    .we    (ctx_we),
    .waddr (waddr),
    .wdata (ctx_wdata),
    .raddr (raddr),
    .rdata (ctx_rdata)
  );

  always_comb begin
    stat.hit_free    = (st_r[ptr_r] == prrs_pkg::ST_FREE);
    stat.hit_ready   = (st_r[ptr_r] == prrs_pkg::ST_READY);
    stat.create_last = (ptr_r == LAST);
    stat.sched_last  = (wrap_inc(ptr_r) == cur_r);
    stat.cur_live    = (st_r[cur_r] != prrs_pkg::ST_FREE);
    stat.lk_hit      = (st_r[lk_idx_r] != prrs_pkg::ST_FREE) && (id_rdata == req_r.lookup_id);
    stat.lk_last     = (lk_idx_r == LAST);
  end

  always_comb begin
    out_nxt       = '0;
    out_valid_nxt = cmd inside {prrs_pkg::CMD_CREATE, prrs_pkg::CMD_FULL,
                                prrs_pkg::CMD_IDLE_RES, prrs_pkg::CMD_READ_OUT,
                                prrs_pkg::CMD_EXIT, prrs_pkg::CMD_LK_HIT,
                                prrs_pkg::CMD_LK_MISS};
    case (cmd)
      prrs_pkg::CMD_CREATE: begin
        out_nxt.status  = prrs_pkg::STAT_OK;
        out_nxt.task_id = next_id_r;
        out_nxt.slot    = to_slot(ptr_r);
      end
      prrs_pkg::CMD_FULL: begin
        out_nxt.status = prrs_pkg::STAT_FULL;
      end
      prrs_pkg::CMD_IDLE_RES: begin
        out_nxt.status = prrs_pkg::STAT_IDLE;
      end
      prrs_pkg::CMD_READ_OUT: begin
        out_nxt.status      = prrs_pkg::STAT_OK;
        out_nxt.context_out = ctx_rdata;
        out_nxt.task_id     = id_rdata;
        out_nxt.slot        = to_slot(cur_r);
        out_nxt.switched    = sw_r;
      end
      prrs_pkg::CMD_LK_HIT: begin
        out_nxt.status  = prrs_pkg::STAT_OK;
        out_nxt.task_id = id_rdata;
        out_nxt.slot    = to_slot(lk_idx_r);
      end
      prrs_pkg::CMD_LK_MISS: begin
        out_nxt.status = prrs_pkg::STAT_NOT_FOUND;
      end
      default: begin
        out_nxt.status = prrs_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st_r[i] <= prrs_pkg::ST_FREE;
      end
      cur_r       <= '0;
      ptr_r       <= '0;
      lk_idx_r    <= '0;
      next_id_r   <= 32'd1;
      sw_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (cmd)
        prrs_pkg::CMD_LOAD: begin
          ptr_r <= (in_data.kind == prrs_pkg::KIND_SCHED) ? wrap_inc(cur_r) : '0;
        end
        prrs_pkg::CMD_STEP: begin
          ptr_r <= wrap_inc(ptr_r);
        end
        prrs_pkg::CMD_LK_STEP: begin
          lk_idx_r <= ptr_r;
          ptr_r    <= wrap_inc(ptr_r);
        end
        prrs_pkg::CMD_CREATE: begin
          st_r[ptr_r] <= prrs_pkg::ST_READY;
          next_id_r   <= next_id_r + 32'd1;
        end
        prrs_pkg::CMD_SWITCH: begin
          if (st_r[cur_r] == prrs_pkg::ST_RUNNING) begin
            st_r[cur_r] <= prrs_pkg::ST_READY;
          end
          st_r[ptr_r] <= prrs_pkg::ST_RUNNING;
          cur_r       <= ptr_r;
          sw_r        <= 1'b1;
        end
        prrs_pkg::CMD_KEEP: begin
          st_r[cur_r] <= prrs_pkg::ST_RUNNING;
          sw_r        <= 1'b0;
        end
        prrs_pkg::CMD_EXIT: begin
          st_r[cur_r] <= prrs_pkg::ST_FREE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == prrs_pkg::CMD_LOAD) begin
      req_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/prrs_chk.sv]
module prrs_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input prrs_pkg::out_t out_data
);

  // every result comes from a request still being worked on
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a request in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted beat did not start work");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result beats in a row");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != prrs_pkg::STAT_OK |->
      out_data.context_out == 64'd0 && out_data.task_id == 32'd0 &&
      out_data.slot == 4'd0 && !out_data.switched)
    else $error("failed request carries nonzero fields");

  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.switched |-> out_data.status == prrs_pkg::STAT_OK)
    else $error("switch reported with error status");

endmodule

bind process_table_round_robin_scheduler prrs_chk u_prrs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
